// ===== rtl/wtsp_pkg.sv =====
// Shared constants for the world to screen projection unit.
`timescale 1ns / 1ps
`default_nettype none

package wtsp_pkg;

    // Fixed-point and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int SCALE_W       = 15;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    // Quotient bits kept by the divider: one above the 32-bit result range
    localparam int QUO_W         = 33;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_CD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_AB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_CD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_AB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_CD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

    // Viewport reset size
    localparam logic [SCALE_W-1:0] WIDTH_RST  = 15'd640;
    localparam logic [SCALE_W-1:0] HEIGHT_RST = 15'd480;

endpackage

`default_nettype wire

// ===== rtl/wtsp_dot.sv =====
// Three-stage dot product of one matrix row with a point (implicit w of one).
`timescale 1ns / 1ps
`default_nettype none

module wtsp_dot
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DOT_W     = 66 - FRAC_BITS
)
(
    input  wire                     clk,
    input  wire                     en,
    input  wire  [CFG_W-1:0]        coef_ab,
    input  wire  [CFG_W-1:0]        coef_cd,
    input  wire  signed [COEF_W-1:0] px,
    input  wire  signed [COEF_W-1:0] py,
    input  wire  signed [COEF_W-1:0] pz,
    output logic signed [DOT_W-1:0] dot
);

    logic signed [2*COEF_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [2*COEF_W-1:0] p0_next, p1_next, p2_next;
    logic signed [COEF_W-1:0]   c3_reg;
    logic signed [DOT_W-1:0]    sa_reg, sb_reg, sa_next, sb_next;
    logic signed [DOT_W-1:0]    dot_reg, dot_next;

    // Form the three products
    always_comb
    begin
        p0_next = $signed(coef_ab[COEF_W-1:0]) * px;
        p1_next = $signed(coef_ab[CFG_W-1:COEF_W]) * py;
        p2_next = $signed(coef_cd[COEF_W-1:0]) * pz;
    end

    // Floor each product to Q.F and add in pairs
    always_comb
    begin
        sa_next = DOT_W'(p0_reg >>> FRAC_BITS) + DOT_W'(p1_reg >>> FRAC_BITS);
        sb_next = DOT_W'(p2_reg >>> FRAC_BITS) + DOT_W'(c3_reg);
        dot_next = sa_reg + sb_reg;
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            c3_reg  <= $signed(coef_cd[CFG_W-1:COEF_W]);
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

`default_nettype wire

// ===== rtl/wtsp_div.sv =====
// Viewport map: floor(num * scale * 2^F / (2w)) through a bit-per-stage divider, saturated.
`timescale 1ns / 1ps
`default_nettype none

module wtsp_div
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DOT_W     = 66 - FRAC_BITS
)
(
    input  wire                      clk,
    input  wire                      en,
    input  wire  signed [DOT_W:0]    num,
    input  wire  signed [DOT_W-1:0]  w,
    input  wire  [SCALE_W-1:0]       scale,
    output logic signed [COEF_W-1:0] res
);

    localparam int MAG_W  = DOT_W + 1;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int DEN_W  = DOT_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int TOP_W  = DVD_W - QUO_W;
    localparam int CMP_W  = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    // Sign split
    logic             neg_a_reg;
    logic [MAG_W-1:0] mag_a_reg;
    logic [DEN_W-1:0] den_a_reg;
    logic [SCALE_W-1:0] scale_a_reg;

    // Scale product
    logic              neg_b_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [DEN_W-1:0]  den_b_reg;

    // Divider stages, index 0 is the setup stage
    logic              neg_reg [0:QUO_W];
    logic              ovf_reg [0:QUO_W];
    logic [DEN_W-1:0]  den_reg [0:QUO_W];
    logic [REM_W-2:0]  rem_reg [0:QUO_W];
    logic [QUO_W-1:0]  low_reg [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg [0:QUO_W];

    logic [DVD_W-1:0]  dvd;
    logic [CMP_W-1:0]  top_cmp, den_cmp;
    logic [QUO_W:0]    qn;
    logic signed [COEF_W-1:0] res_reg, res_next;

    // Take magnitude and sign; the divisor is 2w
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg   <= num[DOT_W];
            mag_a_reg   <= num[DOT_W] ? MAG_W'(-num) : MAG_W'(num);
            den_a_reg   <= {w[DOT_W-2:0], 1'b0};
            scale_a_reg <= scale;
        end
    end

    // Multiply by the viewport size
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_b_reg  <= neg_a_reg;
            prod_b_reg <= PROD_W'(mag_a_reg) * PROD_W'(scale_a_reg);
            den_b_reg  <= den_a_reg;
        end
    end

    // Check the upper dividend bits against the divisor
    always_comb
    begin
        dvd     = {prod_b_reg, {FRAC_BITS{1'b0}}};
        top_cmp = CMP_W'(dvd[DVD_W-1:QUO_W]);
        den_cmp = CMP_W'(den_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg_b_reg;
            ovf_reg[0] <= (top_cmp >= den_cmp);
            den_reg[0] <= den_b_reg;
            rem_reg[0] <= (REM_W-1)'(top_cmp);
            low_reg[0] <= dvd[QUO_W-1:0];
            quo_reg[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QUO_W-1-k]};
            take  = (trial >= REM_W'(den_reg[k]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_reg[k];
                rem_reg[k+1] <= take ? (REM_W-1)'(trial - REM_W'(den_reg[k]))
                                     : (REM_W-1)'(trial);
                quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], take};
            end
        end
    end

    // Round negatives toward minus infinity and saturate
    always_comb
    begin
        qn = (QUO_W+1)'(quo_reg[QUO_W]) + (QUO_W+1)'(rem_reg[QUO_W] != '0);
        if (!neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || quo_reg[QUO_W][QUO_W-1:COEF_W-1] != '0)
                res_next = {1'b0, {(COEF_W-1){1'b1}}};
            else
                res_next = $signed(quo_reg[QUO_W][COEF_W-1:0]);
        end
        else
        begin
            if (ovf_reg[QUO_W] || qn > (QUO_W+1)'({1'b1, {(COEF_W-1){1'b0}}}))
                res_next = {1'b1, {(COEF_W-1){1'b0}}};
            else
                res_next = $signed(-qn[COEF_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/world_to_screen_projection_unit.sv =====
// Top level: configuration registers, row dot products, viewport maps and output stage.
// Path of a word: dot-product stages, numerator register, divider stages, output register.
// Throughput: one word per cycle unless stalled; the bit-per-stage divider keeps every stage busy.
// A stalled output freezes the whole pipeline; input is accepted whenever the output moves or is empty.
// Reset is asynchronous, active low: it clears all valid bits, zeroes the matrix rows,
// and sets the viewport to 640 by 480.
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection_unit
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    // tdata: point_x, point_y, point_z
    input  wire  [3*COEF_W-1:0]  s_axis_tdata,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: screen_x, screen_y
    output logic [2*COEF_W-1:0]  m_axis_tdata,
    // tuser: on_screen
    output logic                 m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    input  wire                  cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0] cfg_addr,
    input  wire  [CFG_W-1:0]     cfg_wdata
);

    localparam int DOT_W   = 66 - FRAC_BITS;
    localparam int DIV_LAT = QUO_W + 4;
    localparam int TOTAL   = DIV_LAT + 5;
    localparam logic signed [DOT_W-1:0] W_MIN =
        DOT_W'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);

    logic [CFG_W-1:0]   coef_reg [0:5];
    logic [SCALE_W-1:0] width_reg, height_reg;

    logic               en;
    logic               vld_reg [0:TOTAL-1];
    // Flag chain spans the numerator stage plus the divider
    logic               on_reg  [0:DIV_LAT];

    logic signed [DOT_W-1:0] cx, cy, w;
    logic signed [DOT_W:0]   numx_reg, numy_reg;
    logic signed [DOT_W-1:0] w_reg;
    logic signed [COEF_W-1:0] sx, sy;
    logic signed [COEF_W-1:0] outx_reg, outy_reg;
    logic               out_on_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                coef_reg[i] <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ROW0_AB: coef_reg[0] <= cfg_wdata;
                REG_ROW0_CD: coef_reg[1] <= cfg_wdata;
                REG_ROW1_AB: coef_reg[2] <= cfg_wdata;
                REG_ROW1_CD: coef_reg[3] <= cfg_wdata;
                REG_ROW3_AB: coef_reg[4] <= cfg_wdata;
                REG_ROW3_CD: coef_reg[5] <= cfg_wdata;
                REG_WIDTH:   width_reg   <= cfg_wdata[SCALE_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_wdata[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Advance the pipeline unless a finished word is held
    assign en            = !vld_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = en;

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < TOTAL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Row dot products: x, y and w
    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_x (
        .clk(clk), .en(en), .coef_ab(coef_reg[0]), .coef_cd(coef_reg[1]),
        .px($signed(s_axis_tdata[COEF_W-1:0])),
        .py($signed(s_axis_tdata[2*COEF_W-1:COEF_W])),
        .pz($signed(s_axis_tdata[3*COEF_W-1:2*COEF_W])),
        .dot(cx)
    );

    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_y (
        .clk(clk), .en(en), .coef_ab(coef_reg[2]), .coef_cd(coef_reg[3]),
        .px($signed(s_axis_tdata[COEF_W-1:0])),
        .py($signed(s_axis_tdata[2*COEF_W-1:COEF_W])),
        .pz($signed(s_axis_tdata[3*COEF_W-1:2*COEF_W])),
        .dot(cy)
    );

    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_w (
        .clk(clk), .en(en), .coef_ab(coef_reg[4]), .coef_cd(coef_reg[5]),
        .px($signed(s_axis_tdata[COEF_W-1:0])),
        .py($signed(s_axis_tdata[2*COEF_W-1:COEF_W])),
        .pz($signed(s_axis_tdata[3*COEF_W-1:2*COEF_W])),
        .dot(w)
    );

    // Form numerators w + X and w - Y, flag w against the threshold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg <= (DOT_W+1)'(w) + (DOT_W+1)'(cx);
            numy_reg <= (DOT_W+1)'(w) - (DOT_W+1)'(cy);
            w_reg    <= w;
            on_reg[0] <= (w >= W_MIN);
            for (int i = 1; i <= DIV_LAT; i++)
                on_reg[i] <= on_reg[i-1];
        end
    end

    // Viewport maps
    wtsp_div #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_div_x (
        .clk(clk), .en(en), .num(numx_reg), .w(w_reg), .scale(width_reg), .res(sx)
    );

    wtsp_div #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_div_y (
        .clk(clk), .en(en), .num(numy_reg), .w(w_reg), .scale(height_reg), .res(sy)
    );

    // Zero the coordinates of points off screen
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_on_reg <= on_reg[DIV_LAT];
            outx_reg   <= on_reg[DIV_LAT] ? sx : '0;
            outy_reg   <= on_reg[DIV_LAT] ? sy : '0;
        end
    end

    assign m_axis_tvalid = vld_reg[TOTAL-1];
    assign m_axis_tuser  = out_on_reg;
    assign m_axis_tdata  = {outy_reg, outx_reg};

    // An off-screen word carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("off-screen word with nonzero coordinates");

    // Ready follows the output stage alone
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output stage");

    // A new output word appears only after the pipeline moved
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(en))
        else $error("output valid rose while pipeline was frozen");

    // A frozen pipeline keeps its entry stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg[0] == $past(vld_reg[0])))
        else $error("entry stage changed during stall");

endmodule

`default_nettype wire

// ===== dv/world_to_screen_projection_unit_tb.sv =====
// Self-checking testbench for the world to screen projection unit.
`timescale 1ns / 1ps

module world_to_screen_projection_unit_tb;
    import wtsp_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam longint W_FLOOR = ((64'sd1 <<< FRAC) + 999) / 1000;
    localparam int ONE       = 1 << FRAC;
    localparam int DRAIN_CYC = 60;
    localparam int WDOG_MAX  = 5000;
    localparam int STALL_LEN = 400;

    typedef struct packed {
        logic        on_screen;
        logic [31:0] screen_x;
        logic [31:0] screen_y;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic [95:0]        s_axis_tdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [63:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;

    // Shadow copy of the register file
    logic [63:0]        matrix_regs [8];

    logic [95:0]        point_q [$];
    pixel_t             pixel_q [$];
    int                 err_cnt = 0;
    int                 quiet_cycles = 0;
    bit                 calm;
    bit                 long_stall_req;
    bit                 long_stall_done;
    int                 stall_left;

    world_to_screen_projection_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Dot product of one matrix row with the point, floor after each product
    function automatic longint row_dot(int r, longint px, longint py, longint pz);
        logic [63:0] ab;
        logic [63:0] cd;
        longint acc;
        ab = matrix_regs[2 * r];
        cd = matrix_regs[2 * r + 1];
        acc = (longint'($signed(ab[31:0])) * px) >>> FRAC;
        acc += (longint'($signed(ab[63:32])) * py) >>> FRAC;
        acc += (longint'($signed(cd[31:0])) * pz) >>> FRAC;
        acc += longint'($signed(cd[63:32]));
        return acc;
    endfunction

    // floor(num * scale * 2^F / (2w)), saturated to 32 bits
    function automatic logic [31:0] viewport_pos(longint num, longint w, logic [14:0] scale);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        logic signed [127:0] s;
        n = num;
        s = {113'd0, scale};
        n = (n * s) <<< FRAC;
        d = w * 2;
        q = n / d;
        if (n < 0 && (n % d) != 0)
            q = q - 1;
        if (q > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (q < -128'sd2147483648)
            return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic pixel_t project_point(logic [95:0] pt);
        longint px;
        longint py;
        longint pz;
        longint w;
        pixel_t res;
        px = $signed(pt[31:0]);
        py = $signed(pt[63:32]);
        pz = $signed(pt[95:64]);
        w = row_dot(2, px, py, pz);
        res = '0;
        if (w >= W_FLOOR)
        begin
            res.on_screen = 1'b1;
            res.screen_x = viewport_pos(w + row_dot(0, px, py, pz), w, matrix_regs[6][14:0]);
            res.screen_y = viewport_pos(w - row_dot(1, px, py, pz), w, matrix_regs[7][14:0]);
        end
        return res;
    endfunction

    // Input driver: pop the next point when the bus is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (point_q.size() > 0 && (calm || $urandom_range(99) >= 15))
            begin
                s_axis_tdata  <= point_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Predict on every accepted input word
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pixel_q.push_back(project_point(s_axis_tdata));
    end

    // Output ready: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready   <= 1'b0;
            stall_left      <= 0;
            long_stall_done <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (long_stall_req && !long_stall_done)
        begin
            stall_left      <= STALL_LEN;
            long_stall_done <= 1'b1;
            m_axis_tready   <= 1'b0;
        end
        else
            m_axis_tready <= calm || $urandom_range(99) >= 15;
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        pixel_t exp_px;
        pixel_t act_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act_px = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]};
            if (pixel_q.size() == 0)
            begin
                err_cnt <= err_cnt + 1;
                $display("%0t: unexpected word, actual %h", $realtime, act_px);
            end
            else
            begin
                exp_px = pixel_q.pop_front();
                if (exp_px !== act_px)
                begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: mismatch, expected on=%b x=%h y=%h, actual on=%b x=%h y=%h",
                             $realtime, exp_px.on_screen, exp_px.screen_x,
                             exp_px.screen_y, act_px.on_screen, act_px.screen_x,
                             act_px.screen_y);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("world_to_screen_projection_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        matrix_regs[idx] = (idx >= REG_WIDTH) ? {49'd0, val[14:0]} : val;
    endtask

    task automatic load_matrix(logic [63:0] r0ab, logic [63:0] r0cd, logic [63:0] r1ab,
                               logic [63:0] r1cd, logic [63:0] r3ab, logic [63:0] r3cd,
                               logic [14:0] vw, logic [14:0] vh);
        write_reg(REG_ROW0_AB, r0ab);
        write_reg(REG_ROW0_CD, r0cd);
        write_reg(REG_ROW1_AB, r1ab);
        write_reg(REG_ROW1_CD, r1cd);
        write_reg(REG_ROW3_AB, r3ab);
        write_reg(REG_ROW3_CD, r3cd);
        write_reg(REG_WIDTH, {49'd0, vw});
        write_reg(REG_HEIGHT, {49'd0, vh});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every word is through, then let the pipeline settle
    task automatic drain();
        while (point_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic add_point(int x, int y, int z);
        point_q.push_back({z, y, x});
    endtask

    function automatic logic [31:0] rand_coef();
        return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    function automatic logic [14:0] rand_size();
        case ($urandom_range(5))
            0: return 15'd1;
            1: return 15'd16384;
            2: return 15'd32767;
            3: return 15'd0;
            default: return 15'($urandom_range(1, 16384));
        endcase
    endfunction

    function automatic int rand_span();
        int bits;
        bits = $urandom_range(1, 31);
        return $urandom() >> (32 - bits);
    endfunction

    initial
    begin
        logic [14:0] vw;
        logic [14:0] vh;
        int x;
        int z;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        calm          = 1'b0;
        long_stall_req = 1'b0;
        for (int i = 0; i < 8; i++)
            matrix_regs[i] = '0;
        matrix_regs[REG_WIDTH]  = WIDTH_RST;
        matrix_regs[REG_HEIGHT] = HEIGHT_RST;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Zero matrix after reset: every point is off screen
        add_point(ONE, ONE, ONE);
        add_point(-1, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // Plain perspective: x/z, y/z, w = z
        load_matrix({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {32'd0, ONE},
                    15'd640, 15'd480);
        add_point(0, 0, ONE);
        add_point(0, 0, int'(W_FLOOR));
        add_point(0, 0, int'(W_FLOOR) - 1);
        add_point(0, 0, 0);
        add_point(ONE, ONE, -ONE);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, int'(W_FLOOR));
        add_point(32'h8000_0000, 32'h7FFF_FFFF, int'(W_FLOOR));
        add_point(ONE, -ONE, ONE);
        add_point(-ONE, ONE, ONE);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_point(-3 * ONE, 5 * ONE, 7 * ONE);
        drain();

        // Viewport size extremes, zero included
        load_matrix({32'd0, ONE}, {32'd3 << FRAC, 32'd0}, {ONE, 32'd0}, 64'd0,
                    {32'd0, 32'hFFFF_0000}, {32'd0, ONE}, 15'd32767, 15'd0);
        add_point(ONE, ONE, 2 * ONE);
        add_point(-ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(12345, -6789, 10 * ONE);
        drain();
        load_matrix({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {32'd0, ONE},
                    15'd1, 15'd16384);
        add_point(ONE, ONE, 2 * ONE);
        add_point(-ONE, -ONE, 3 * ONE);
        drain();

        // Random phases: mostly sane perspective matrices, some pure noise
        for (int ph = 0; ph < 10; ph++)
        begin
            vw = rand_size();
            vh = rand_size();
            if (ph % 4 == 3)
                load_matrix({$urandom(), $urandom()}, {$urandom(), $urandom()},
                            {$urandom(), $urandom()}, {$urandom(), $urandom()},
                            {$urandom(), $urandom()}, {$urandom(), $urandom()}, vw, vh);
            else
                load_matrix({rand_coef() >>> 3, rand_coef() + ONE},
                            {rand_coef() << 4, rand_coef() >>> 3},
                            {rand_coef() + ONE, rand_coef() >>> 3},
                            {rand_coef() << 4, rand_coef() >>> 3},
                            {rand_coef() >>> 4, rand_coef() >>> 4},
                            {rand_coef(), rand_coef() + ONE}, vw, vh);
            calm = (ph == 2 || ph == 6);
            for (int i = 0; i < 120; i++)
            begin
                if ($urandom_range(9) < 2)
                    point_q.push_back({$urandom(), $urandom(), $urandom()});
                else
                begin
                    z = $urandom_range(int'(W_FLOOR), 1 << ($urandom_range(8, 30)));
                    x = rand_span();
                    add_point($urandom_range(1) ? x : -x, $urandom_range(1) ? rand_span()
                              : -rand_span(), z);
                end
            end
            if (ph == 2)
                long_stall_req = 1'b1;
            drain();
        end
        calm = 1'b0;

        if (err_cnt == 0)
            $display("world_to_screen_projection_unit test passed");
        else
            $display("world_to_screen_projection_unit test failed");
        $finish;
    end

endmodule
